FILE: hdl/rfsm_pkg.sv
package rfsm_pkg;

  localparam int DATA_W         = 64;
  localparam int MAX_RANGES_DEF = 32;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_IMAGE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXEC_MODE    = CFG_IDX_W'(1);

endpackage

FILE: hdl/rfsm_if.sv
interface rfsm_rec_if;
  logic                        valid;
  logic                        ready;
  logic [rfsm_pkg::DATA_W-1:0] record_image;
  logic [rfsm_pkg::DATA_W-1:0] record_offset;
  logic [rfsm_pkg::DATA_W-1:0] record_size;
  logic                        record_exec;
  logic                        record_last;

  modport source (output valid, record_image, record_offset, record_size, record_exec,
                  record_last, input ready);
  modport sink (input valid, record_image, record_offset, record_size, record_exec,
                record_last, output ready);
endinterface

interface rfsm_rng_if;
  logic                        valid;
  logic                        ready;
  logic [rfsm_pkg::DATA_W-1:0] range_start;
  logic [rfsm_pkg::DATA_W-1:0] range_end;
  logic                        range_valid;
  logic                        overflowed;
  logic                        run_last;

  modport source (output valid, range_start, range_end, range_valid, overflowed, run_last,
                  input ready);
  modport sink (input valid, range_start, range_end, range_valid, overflowed, run_last,
                output ready);
endinterface

interface rfsm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rfsm_pkg::CFG_IDX_W-1:0] reg_index;
  logic [rfsm_pkg::DATA_W-1:0]    data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: hdl/range_filter_sort_merge.sv
// channel | dir | payload
// rec     | in  | record_image, record_offset, record_size, record_exec, record_last
// rng     | out | range_start, range_end, range_valid, overflowed, run_last
// cfg     | in  | reg_index, data (0 target_image, 1 exec mode)
//
// A dropped record goes back to idle after the check; an inserted one is compared against
// the stored ranges from the top (one memory read port walks the sorted store, one compare per step).
// A last record adds a merge walk over the stored ranges, ending in a range marked run_last.
// rst is synchronous; the store needs no clearing, since the count resets.
// rec is not ready while a request is in work; results wait in an output register.
module range_filter_sort_merge #(
  parameter int MAX_RANGES = rfsm_pkg::MAX_RANGES_DEF
) (
  input logic        clk,
  input logic        rst,
  rfsm_rec_if.sink   rec,
  rfsm_rng_if.source rng,
  rfsm_cfg_if.sink   cfg
);

  localparam int W     = rfsm_pkg::DATA_W;
  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_INS_RD, S_INS_CMP, S_INS_PUT, S_END,
    S_MRG_LOAD, S_MRG_CMP1, S_MRG_CMP2, S_MRG_EMIT, S_MRG_NEXT, S_FINAL
  } state_t;

  state_t           state;
  logic [W-1:0]     target_image;
  logic             need_exec;
  logic [W-1:0]     off;
  logic [W-1:0]     end_sat;
  logic             hit;
  logic             last;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] idx;
  logic             ovf;
  logic [W-1:0]     cs;
  logic [W-1:0]     ce;

  logic [W-1:0]     mem_start [MAX_RANGES];
  logic [W-1:0]     mem_end   [MAX_RANGES];
  logic [W-1:0]     rd_start;
  logic [W-1:0]     rd_end;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [W-1:0]     wr_start;
  logic [W-1:0]     wr_end;

  logic [W-1:0]     cmp_a;
  logic [W-1:0]     cmp_b;
  logic             cmp_gt;
  logic [W:0]       sum;
  logic             rec_hit;
  logic             out_free;
  logic             out_load;
  logic             out_valid;
  logic [W-1:0]     out_start;
  logic [W-1:0]     out_end;
  logic             out_rvalid;
  logic             out_ovf;
  logic             out_last;

  assign rec.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rng.valid       = out_valid;
  assign rng.range_start = out_start;
  assign rng.range_end   = out_end;
  assign rng.range_valid = out_rvalid;
  assign rng.overflowed  = out_ovf;
  assign rng.run_last    = out_last;

  assign out_free = !out_valid || rng.ready;
  assign out_load = out_free && ((state == S_END && last && count == '0) ||
                                 state == S_MRG_EMIT || state == S_FINAL);
  assign sum      = {1'b0, rec.record_offset} + {1'b0, rec.record_size};
  assign rec_hit  = (rec.record_image == target_image) && (rec.record_size != '0) &&
                    (!need_exec || rec.record_exec);

  // shared comparator
  always_comb begin
    case (state)
      S_CHECK: begin
        cmp_a = end_sat;
        cmp_b = off;
      end
      S_INS_CMP: begin
        cmp_a = rd_start;
        cmp_b = off;
      end
      S_MRG_CMP1: begin
        cmp_a = rd_start;
        cmp_b = ce;
      end
      default: begin
        cmp_a = rd_end;
        cmp_b = ce;
      end
    endcase
  end
  assign cmp_gt = cmp_a > cmp_b;

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = pos[IDX_W-1:0];
    wr_start = off;
    wr_end   = end_sat;
    case (state)
      S_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(pos - CNT_ONE);
      end
      S_INS_CMP: begin
        wr_en    = cmp_gt;
        wr_start = rd_start;
        wr_end   = rd_end;
      end
      S_INS_PUT: begin
        wr_en = 1'b1;
      end
      S_END: begin
        rd_en = 1'b1;
      end
      S_MRG_LOAD, S_MRG_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(idx + CNT_ONE);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_end[wr_addr]   <= wr_end;
    end
    if (rd_en) begin
      rd_start <= mem_start[rd_addr];
      rd_end   <= mem_end[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      target_image <= '0;
      need_exec    <= 1'b0;
      count        <= '0;
      ovf          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.reg_index)
          rfsm_pkg::CFG_TARGET_IMAGE: target_image <= cfg.data;
          rfsm_pkg::CFG_EXEC_MODE:    need_exec    <= cfg.data[0];
          default: ;
        endcase
      end
      if (rng.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (rec.valid) begin
            off     <= rec.record_offset;
            end_sat <= sum[W] ? '1 : sum[W-1:0];
            hit     <= rec_hit;
            last    <= rec.record_last;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          pos <= count;
          if (!(hit && cmp_gt)) begin
            state <= S_END;
          end else if (count == CNT_MAX) begin
            ovf   <= 1'b1;
            state <= S_END;
          end else if (count == '0) begin
            state <= S_INS_PUT;
          end else begin
            state <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (cmp_gt) begin
            pos   <= pos - CNT_ONE;
            state <= (pos == CNT_ONE) ? S_INS_PUT : S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          count <= count + CNT_ONE;
          state <= S_END;
        end
        S_END: begin
          idx <= '0;
          if (!last) begin
            state <= S_IDLE;
          end else if (count != '0) begin
            state <= S_MRG_LOAD;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_start  <= '0;
            out_end    <= '0;
            out_rvalid <= 1'b0;
            out_ovf    <= ovf;
            out_last   <= 1'b1;
            ovf        <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_MRG_LOAD: begin
          cs  <= rd_start;
          ce  <= rd_end;
          idx <= idx + CNT_ONE;
          state <= (count == CNT_ONE) ? S_FINAL : S_MRG_CMP1;
        end
        S_MRG_CMP1: begin
          state <= cmp_gt ? S_MRG_EMIT : S_MRG_CMP2;
        end
        S_MRG_CMP2: begin
          if (cmp_gt) begin
            ce <= rd_end;
          end
          state <= S_MRG_NEXT;
          if (idx + CNT_ONE == count) begin
            state <= S_FINAL;
          end
        end
        S_MRG_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_start  <= cs;
            out_end    <= ce;
            out_rvalid <= 1'b1;
            out_ovf    <= ovf;
            out_last   <= 1'b0;
            cs         <= rd_start;
            ce         <= rd_end;
            state      <= (idx + CNT_ONE == count) ? S_FINAL : S_MRG_NEXT;
          end
        end
        S_MRG_NEXT: begin
          idx   <= idx + CNT_ONE;
          state <= S_MRG_CMP1;
        end
        S_FINAL: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_start  <= cs;
            out_end    <= ce;
            out_rvalid <= 1'b1;
            out_ovf    <= ovf;
            out_last   <= 1'b1;
            count      <= '0;
            ovf        <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("range count above capacity");
  a_wr_addr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CNT_W'(wr_addr) < CNT_MAX))
    else $error("store write out of range");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (rec.valid && rec.ready) |=> !rec.ready)
    else $error("ready right after accepted request");
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && out_free) |=> (count == '0 && !ovf && out_valid && out_last))
    else $error("set not closed after final range");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_rvalid) |-> out_last)
    else $error("empty result not marked last");
`endif

endmodule
